/* rtl/bmppt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmppt_pkg
// shared types and constants for the bisection mppt tracker
// ----------------------------------------------------------------------------
package bmppt_pkg;

  localparam int VOLT_BITS_DEF = 16;
  localparam int CUR_BITS_DEF  = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int VREF_W    = 16;
  localparam int DEC_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_V = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_V = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL   = 2'd2;

  localparam logic [CFG_W-1:0] CFG_MAX_V_RST = 16'hFFFF;
  localparam logic [CFG_W-1:0] CFG_MIN_V_RST = 16'h0000;
  localparam logic [CFG_W-1:0] CFG_TOL_RST   = 16'd10;

  typedef enum logic [DEC_W-1:0] {
    DEC_FIRST = 3'd0,
    DEC_HOLD  = 3'd1,
    DEC_RIGHT = 3'd2,
    DEC_LEFT  = 3'd3,
    DEC_FLAT  = 3'd4
  } decision_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic restart;
    logic div_start;
    logic div_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic func;
    logic phase;
    logic flat;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bmppt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmppt_ctrl
// sequencer: capture, multiply, serial divide, then commit one result
// ----------------------------------------------------------------------------
module bmppt_ctrl
  import bmppt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (sts_i.func) state_d = ST_IDLE;
        else if (!sts_i.phase || sts_i.flat) state_d = ST_EMIT;
        else state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_MUL: begin
        cmd_o.restart   = sts_i.func;
        cmd_o.div_start = !sts_i.func && sts_i.phase && !sts_i.flat;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* rtl/bmppt_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmppt_dpath
// search state, config registers, multiplier, restoring divider, result reg
// ----------------------------------------------------------------------------
module bmppt_dpath
  import bmppt_pkg::*;
#(
  parameter int VOLT_BITS = VOLT_BITS_DEF,
  parameter int CUR_BITS  = CUR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_func_i,
  input  logic [VOLT_BITS-1:0] in_volt_i,
  input  logic [CUR_BITS-1:0]  in_cur_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [VREF_W-1:0]    out_vref_o,
  output logic [DEC_W-1:0]     out_dec_o
);

  localparam int P_W   = VOLT_BITS + CUR_BITS;
  localparam int CNT_W = $clog2(P_W + 1);
  localparam int CMP_W = (P_W > CFG_W) ? P_W : CFG_W;

  logic [CFG_W-1:0]     cfg_max_q, cfg_min_q, cfg_tol_q;
  logic                 phase_q;
  logic [VOLT_BITS-1:0] left_q, right_q, last_v_q;
  logic [P_W-1:0]       last_p_q;
  logic                 func_q;
  logic [VOLT_BITS-1:0] v_q;
  logic [P_W-1:0]       p_q;

  // divider
  logic [VOLT_BITS-1:0] rem_q, dvs_q;
  logic [P_W-1:0]       quo_q;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q;

  logic                 out_valid_q;
  logic [VREF_W-1:0]    out_vref_q;
  logic [DEC_W-1:0]     out_dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max_q <= CFG_MAX_V_RST;
      cfg_min_q <= CFG_MIN_V_RST;
      cfg_tol_q <= CFG_TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_IDX_MAX_V: cfg_max_q <= cfg_wdata_i;
        CFG_IDX_MIN_V: cfg_min_q <= cfg_wdata_i;
        CFG_IDX_TOL:   cfg_tol_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input capture and product, both ready for the mul state
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_func_i;
      v_q    <= in_volt_i;
      p_q    <= P_W'(in_volt_i) * P_W'(in_cur_i);
    end
  end

  // slope operands
  logic                 dp_neg, dv_neg;
  logic [P_W-1:0]       dp_mag;
  logic [VOLT_BITS-1:0] dv_mag;
  logic [VOLT_BITS:0]   trial;
  logic                 trial_ge;

  assign dp_neg   = p_q < last_p_q;
  assign dv_neg   = v_q < last_v_q;
  assign dp_mag   = dp_neg ? (last_p_q - p_q) : (p_q - last_p_q);
  assign dv_mag   = dv_neg ? (last_v_q - v_q) : (v_q - last_v_q);
  assign trial    = {rem_q, quo_q[P_W-1]};
  assign trial_ge = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= dp_mag;
      dvs_q <= dv_mag;
      neg_q <= dp_neg ^ dv_neg;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? VOLT_BITS'(trial - {1'b0, dvs_q}) : VOLT_BITS'(trial);
      quo_q <= {quo_q[P_W-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= CNT_W'(P_W);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // result selection
  logic [VOLT_BITS:0]   sum;
  logic [VOLT_BITS-1:0] mid_lo, mid_hi, mid_cur;
  logic [VOLT_BITS:0]   sum_lo, sum_hi;
  logic                 steep;
  logic [VOLT_BITS-1:0] vref_d;
  decision_e            dec_d;

  assign sum     = {1'b0, left_q} + {1'b0, right_q};
  assign sum_lo  = {1'b0, v_q} + {1'b0, right_q};
  assign sum_hi  = {1'b0, left_q} + {1'b0, v_q};
  assign mid_cur = sum[VOLT_BITS:1];
  assign mid_lo  = sum_lo[VOLT_BITS:1];
  assign mid_hi  = sum_hi[VOLT_BITS:1];
  assign steep   = CMP_W'(quo_q) > CMP_W'(cfg_tol_q);

  always_comb begin
    if (!phase_q) begin
      vref_d = mid_cur;
      dec_d  = DEC_FIRST;
    end else if (v_q == last_v_q) begin
      vref_d = '0;
      dec_d  = DEC_FLAT;
    end else if (!steep) begin
      vref_d = v_q;
      dec_d  = DEC_HOLD;
    end else if (!neg_q) begin
      vref_d = mid_lo;
      dec_d  = DEC_RIGHT;
    end else begin
      vref_d = mid_hi;
      dec_d  = DEC_LEFT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      left_q   <= VOLT_BITS'(CFG_MIN_V_RST);
      right_q  <= VOLT_BITS'(CFG_MAX_V_RST);
      last_v_q <= '0;
      last_p_q <= '0;
    end else if (cmd_i.restart) begin
      phase_q <= 1'b0;
      left_q  <= VOLT_BITS'(cfg_min_q);
      right_q <= VOLT_BITS'(cfg_max_q);
    end else if (cmd_i.commit) begin
      phase_q  <= 1'b1;
      last_p_q <= p_q;
      last_v_q <= phase_q ? v_q : left_q;
      if (dec_d == DEC_RIGHT) left_q  <= v_q;
      if (dec_d == DEC_LEFT)  right_q <= v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_vref_q <= VREF_W'(vref_d);
      out_dec_q  <= dec_d;
    end
  end

  assign sts_o.func     = func_q;
  assign sts_o.phase    = phase_q;
  assign sts_o.flat     = v_q == last_v_q;
  assign sts_o.div_last = cnt_q == CNT_W'(1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_vref_o  = out_vref_q;
  assign out_dec_o   = out_dec_q;

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an untaken beat");

  a_div_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> cnt_q == CNT_W'(P_W))
    else $error("divider counter not loaded");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_phase_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q) |-> $past(cmd_i.commit))
    else $error("search phase set without a result");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> !cmd_i.commit && !cmd_i.capture)
    else $error("divider step overlaps capture or commit");

endmodule

/* rtl/bisection_mppt_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bisection_mppt_tracker_core
// bisection maximum power point tracker, one reference voltage per non-restart sample
// ----------------------------------------------------------------------------
// One sample at a time. A sample whose slope must be taken passes capture,
// the multiply state, the serial divide and the commit; the restoring
// divider forms the power slope one quotient bit per cycle. A first probe
// or an unchanged voltage skips the divide, and a restart beat ends without
// a result. The result sits in an output register, so the next sample is
// taken while a finished result still waits on m_axis_tready. Configuration
// bound registers take effect at the next restart or reset.
module bisection_mppt_tracker_core
  import bmppt_pkg::*;
#(
  parameter int VOLT_BITS = VOLT_BITS_DEF,
  parameter int CUR_BITS  = CUR_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                      cfg_addr_i,
  input  logic [CFG_W-1:0]                          cfg_wdata_i,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // voltage_mv, current_ma
  input  logic [((VOLT_BITS+CUR_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // func
  input  logic                                      s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // vref_mv
  output logic [VREF_W-1:0]                         m_axis_tdata,
  // decision
  output logic [DEC_W-1:0]                          m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  bmppt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmppt_dpath #(
    .VOLT_BITS (VOLT_BITS),
    .CUR_BITS  (CUR_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tuser),
    .in_volt_i   (s_axis_tdata[VOLT_BITS-1:0]),
    .in_cur_i    (s_axis_tdata[VOLT_BITS+CUR_BITS-1:VOLT_BITS]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_vref_o  (m_axis_tdata),
    .out_dec_o   (m_axis_tuser)
  );

endmodule

/* tb/bmppt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmppt_checker
// watches the sample, result and register ports of the mppt tracker, predicts
// each reference voltage and decision, and compares them in order
// ----------------------------------------------------------------------------
module bmppt_checker
  import bmppt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // voltage_mv, current_ma
  input  logic [31:0]           s_axis_tdata,
  // func
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // vref_mv
  input  logic [VREF_W-1:0]     m_axis_tdata,
  // decision
  input  logic [DEC_W-1:0]      m_axis_tuser,
  output int                    pending_o,
  output int                    fail_count_o
);

  typedef struct packed {
    logic [VREF_W-1:0] vref;
    decision_e         dec;
  } vref_answer_t;

  vref_answer_t vref_answer_q[$];

  logic [CFG_W-1:0] max_v_reg;
  logic [CFG_W-1:0] min_v_reg;
  logic [CFG_W-1:0] tol_reg;
  logic             probed;
  logic [15:0]      lo_bound;
  logic [15:0]      hi_bound;
  logic [15:0]      prev_volt;
  logic [31:0]      prev_power;
  int               fails;

  function automatic logic [15:0] mid_of(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[16:1];
  endfunction

  task automatic track_sample(input logic restart, input logic [15:0] volt,
                              input logic [15:0] amps);
    logic [31:0]  pwr;
    longint       dp;
    longint       dv;
    longint       slope;
    longint       mag;
    vref_answer_t ans;
    pwr = {16'd0, volt} * {16'd0, amps};
    if (restart) begin
      probed   = 1'b0;
      lo_bound = min_v_reg;
      hi_bound = max_v_reg;
      return;
    end
    if (!probed) begin
      ans.vref   = mid_of(lo_bound, hi_bound);
      ans.dec    = DEC_FIRST;
      probed     = 1'b1;
      prev_volt  = lo_bound;
      prev_power = pwr;
    end else begin
      if (volt == prev_volt) begin
        ans.vref = '0;
        ans.dec  = DEC_FLAT;
      end else begin
        dp    = longint'({32'd0, pwr}) - longint'({32'd0, prev_power});
        dv    = longint'({48'd0, volt}) - longint'({48'd0, prev_volt});
        slope = dp / dv;
        mag   = (slope < 0) ? -slope : slope;
        if (mag <= longint'({48'd0, tol_reg})) begin
          ans.vref = volt;
          ans.dec  = DEC_HOLD;
        end else if (slope > 0) begin
          lo_bound = volt;
          ans.vref = mid_of(lo_bound, hi_bound);
          ans.dec  = DEC_RIGHT;
        end else begin
          hi_bound = volt;
          ans.vref = mid_of(lo_bound, hi_bound);
          ans.dec  = DEC_LEFT;
        end
      end
      prev_volt  = volt;
      prev_power = pwr;
    end
    vref_answer_q.push_back(ans);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vref_answer_t ans;
    if (!rst_ni) begin
      max_v_reg  = CFG_MAX_V_RST;
      min_v_reg  = CFG_MIN_V_RST;
      tol_reg    = CFG_TOL_RST;
      probed     = 1'b0;
      lo_bound   = CFG_MIN_V_RST;
      hi_bound   = CFG_MAX_V_RST;
      prev_volt  = '0;
      prev_power = '0;
      fails      = 0;
      vref_answer_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_IDX_MAX_V: max_v_reg = cfg_wdata_i;
          CFG_IDX_MIN_V: min_v_reg = cfg_wdata_i;
          CFG_IDX_TOL:   tol_reg   = cfg_wdata_i;
          default: ;
        endcase
      end
      // result beat is checked before this edge's sample adds its prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (vref_answer_q.size() == 0) begin
          $display("%0t unexpected result beat: vref %0d decision %0d", $time,
                   m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          ans = vref_answer_q.pop_front();
          if (m_axis_tdata !== ans.vref) begin
            $display("%0t vref mismatch: expected %0d actual %0d", $time,
                     ans.vref, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== ans.dec) begin
            $display("%0t decision mismatch: expected %0d actual %0d", $time,
                     ans.dec, m_axis_tuser);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_sample(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
      end
    end
    pending_o    = vref_answer_q.size();
    fail_count_o = fails;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the bisection mppt tracker: directed corner samples, register
// sweeps and closed-loop tracking of random pv curves, under random stalls
// ----------------------------------------------------------------------------
module tb;
  import bmppt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;
  localparam int   SETTLE_CYC   = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [VREF_W-1:0]    m_axis_tdata;
  logic [DEC_W-1:0]     m_axis_tuser;
  int                   pending;
  int                   fail_count;

  logic                 burst;
  logic [15:0]          last_vref;
  logic [15:0]          last_volt;
  int                   voc;
  int                   isc;
  int                   knee;

  bisection_mppt_tracker_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  bmppt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side stalls at random except during a burst
  always @(negedge clk_i) begin
    m_axis_tready <= burst || ($urandom_range(99) >= 24);
  end

  // follow the tracker's own reference for closed-loop samples
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && m_axis_tdata != '0) begin
      last_vref <= m_axis_tdata;
    end
  end

  task automatic send_beat(input logic fn, input logic [15:0] volt, input logic [15:0] amps);
    int gap;
    gap = (!burst && $urandom_range(99) < 24) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {amps, volt};
    if (fn == FUNC_SAMPLE) last_volt = volt;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // a restart leaves no result, so give the block time to settle as well
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [15:0] pv_current(input int volt);
    longint amps;
    if (volt >= voc) return '0;
    if (volt < knee) amps = isc - (longint'(isc / 8) * volt) / knee;
    else amps = (longint'(isc) * (voc - volt)) / (voc - knee);
    return amps[15:0];
  endfunction

  task automatic track_curve(input int count);
    int r;
    int volt;
    int amps;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_beat(FUNC_RESTART, 16'($urandom), 16'($urandom));
      end else if (r < 10) begin
        send_beat(FUNC_SAMPLE, last_volt, 16'($urandom));
      end else if (r < 25) begin
        send_beat(FUNC_SAMPLE, 16'($urandom), 16'($urandom));
      end else begin
        volt = int'(last_vref) + $urandom_range(0, 400) - 200;
        if (volt < 0) volt = 0;
        if (volt > 65535) volt = 65535;
        amps = int'(pv_current(volt)) + $urandom_range(0, 20) - 10;
        if (amps < 0) amps = 0;
        if (amps > 65535) amps = 65535;
        send_beat(FUNC_SAMPLE, volt[15:0], amps[15:0]);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_IDX_MAX_V;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_SAMPLE;
    m_axis_tready = 1'b0;
    burst         = 1'b0;
    last_vref     = 16'd32767;
    last_volt     = '0;
    voc           = 40000;
    isc           = 8000;
    knee          = 30000;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset registers: first probe, unchanged voltage, both moves and holds
    send_beat(FUNC_SAMPLE, 16'hFFFF, 16'hFFFF);
    send_beat(FUNC_SAMPLE, 16'd0, 16'd0);
    send_beat(FUNC_SAMPLE, 16'd20000, 16'd5000);
    send_beat(FUNC_SAMPLE, 16'd40000, 16'd2600);
    send_beat(FUNC_SAMPLE, 16'd50000, 16'd1000);
    send_beat(FUNC_SAMPLE, 16'd45000, 16'd1111);
    send_beat(FUNC_RESTART, 16'hFFFF, 16'hFFFF);
    send_beat(FUNC_SAMPLE, 16'd1, 16'd1);
    send_beat(FUNC_SAMPLE, 16'hFFFF, 16'd0);
    send_beat(FUNC_SAMPLE, 16'd0, 16'hFFFF);

    // crossed bounds, zero tolerance, and a write to an unused index
    drain();
    write_reg(CFG_IDX_MAX_V, 16'd0);
    write_reg(CFG_IDX_MIN_V, 16'hFFFF);
    write_reg(CFG_IDX_TOL, 16'd0);
    write_reg(CFG_IDX_NONE, 16'hFFFF);
    send_beat(FUNC_SAMPLE, 16'd300, 16'd700);
    send_beat(FUNC_RESTART, 16'd0, 16'd0);
    send_beat(FUNC_SAMPLE, 16'd1000, 16'd3000);
    send_beat(FUNC_SAMPLE, 16'd2000, 16'd1000);
    send_beat(FUNC_SAMPLE, 16'd3000, 16'd2000);

    // widest tolerance holds every slope
    drain();
    write_reg(CFG_IDX_MAX_V, 16'hFFFF);
    write_reg(CFG_IDX_MIN_V, 16'd0);
    write_reg(CFG_IDX_TOL, 16'hFFFF);
    send_beat(FUNC_RESTART, 16'd0, 16'd0);
    send_beat(FUNC_SAMPLE, 16'd100, 16'hFFFF);
    send_beat(FUNC_SAMPLE, 16'd101, 16'hFFFF);
    send_beat(FUNC_SAMPLE, 16'hFFFF, 16'd0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      voc  = $urandom_range(20000, 65535);
      isc  = $urandom_range(1000, 65535);
      knee = voc * 3 / 4;
      if (ph == 3) begin
        write_reg(CFG_IDX_MAX_V, 16'($urandom));
        write_reg(CFG_IDX_MIN_V, 16'($urandom));
        write_reg(CFG_IDX_TOL, 16'($urandom_range(0, 2000)));
      end else begin
        write_reg(CFG_IDX_MAX_V, 16'($urandom_range(voc, 65535)));
        write_reg(CFG_IDX_MIN_V, 16'($urandom_range(0, 5000)));
        write_reg(CFG_IDX_TOL, 16'($urandom_range(0, 50)));
      end
      // new bounds only apply after a restart, so skip it now and then
      if (ph != 1) send_beat(FUNC_RESTART, 16'd0, 16'd0);
      burst = (ph == 2);
      track_curve(100);
      burst = 1'b0;
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bmppt_pkg.sv
rtl/bmppt_ctrl.sv
rtl/bmppt_dpath.sv
rtl/bisection_mppt_tracker_core.sv
tb/bmppt_checker.sv
tb/tb.sv
